// ===== src/spi_command_frame_builder_assert.svh =====
// assertion macros for the frame builder checker
`ifndef SPI_COMMAND_FRAME_BUILDER_ASSERT_SVH
`define SPI_COMMAND_FRAME_BUILDER_ASSERT_SVH

// antecedent implies consequent in the next cycle, off during reset
`define SFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

// same, but also checked across reset
`define SFB_ASSERT_ALWAYS_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("frame builder reset check failed");

`endif

// ===== src/sfb_pkg.sv =====
package sfb_pkg;

    localparam int MAX_CHANNELS_DEF = 4;
    localparam int FRAME_BYTES_MAX  = 24;
    localparam int POS_W            = $clog2(FRAME_BYTES_MAX + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BYTES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_FRAME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_ALL_WORDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_ENABLED  = 3'd5;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    // power of two
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0]      command;
        logic [POS_W-1:0] total;
        logic             crc_on;
        logic [POS_W-1:0] crc_pos;
        logic [POS_W-1:0] covered;
    } t_job;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            if (data[k] != c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/sfb_cmd_if.sv =====
interface sfb_cmd_if;
    logic        valid;
    logic        ready;
    logic [15:0] command_word;

    modport source (output valid, output command_word, input ready);
    modport sink (input valid, input command_word, output ready);
endinterface

// ===== src/sfb_frame_if.sv =====
interface sfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== src/sfb_front.sv =====
module sfb_front #(
    parameter int MAX_CHANNELS = sfb_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    sfb_cmd_if.sink                         i_cmd,
    input  logic                            i_q_ready,
    output logic                            o_q_valid,
    output sfb_pkg::t_job                   o_job
);
    import sfb_pkg::*;

    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int FL_W   = $clog2(MAX_CHANNELS + 3);
    localparam int PROD_W = FL_W + 3;

    logic [2:0] r_word_bytes;
    logic [2:0] r_channel_count;
    logic       r_fixed_frame;
    logic       r_crc_enable;
    logic       r_crc_all_words;
    logic       r_conv_enabled;

    logic [2:0]        wb;
    logic [CH_W-1:0]   ch;
    logic [FL_W-1:0]   fl_raw;
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  fl_cut;
    logic [POS_W-1:0]  fl_eff;
    logic [POS_W-1:0]  total;
    logic [POS_W-1:0]  crc_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_bytes    <= 3'd3;
            r_channel_count <= 3'd4;
            r_fixed_frame   <= 1'b1;
            r_crc_enable    <= 1'b0;
            r_crc_all_words <= 1'b0;
            r_conv_enabled  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WORD_BYTES:    r_word_bytes    <= i_cfg_data;
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                CFG_FIXED_FRAME:   r_fixed_frame   <= i_cfg_data[0];
                CFG_CRC_ENABLE:    r_crc_enable    <= i_cfg_data[0];
                CFG_CRC_ALL_WORDS: r_crc_all_words <= i_cfg_data[0];
                CFG_CONV_ENABLED:  r_conv_enabled  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_word_bytes < 3'd2) begin
            wb = 3'd2;
        end else if (r_word_bytes > 3'd4) begin
            wb = 3'd4;
        end else begin
            wb = r_word_bytes;
        end

        if (r_channel_count == 3'd0) begin
            ch = CH_W'(1);
        end else if (int'(r_channel_count) > MAX_CHANNELS) begin
            ch = CH_W'(MAX_CHANNELS);
        end else begin
            ch = CH_W'(r_channel_count);
        end

        if (r_fixed_frame) begin
            fl_raw = FL_W'(ch) + FL_W'(2);
        end else begin
            fl_raw = FL_W'(1) + (r_conv_enabled ? FL_W'(ch) : FL_W'(0))
                   + FL_W'(r_crc_enable);
        end

        prod = PROD_W'(fl_raw) * PROD_W'(wb);

        case (wb)
            3'd2:    fl_cut = POS_W'(FRAME_BYTES_MAX / 2);
            3'd3:    fl_cut = POS_W'(FRAME_BYTES_MAX / 3);
            default: fl_cut = POS_W'(FRAME_BYTES_MAX / 4);
        endcase

        fl_eff  = (prod > PROD_W'(FRAME_BYTES_MAX)) ? fl_cut : POS_W'(fl_raw);
        total   = POS_W'(fl_eff * POS_W'(wb));
        crc_pos = total - POS_W'(wb);
    end

    assign o_job.command = i_cmd.command_word;
    assign o_job.total   = total;
    assign o_job.crc_on  = r_crc_enable && (fl_eff >= POS_W'(2));
    assign o_job.crc_pos = crc_pos;
    assign o_job.covered = r_crc_all_words ? crc_pos : POS_W'(wb);

    assign o_q_valid   = i_cmd.valid;
    assign i_cmd.ready = i_q_ready;

endmodule

// ===== src/sfb_queue.sv =====
module sfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  sfb_pkg::t_job i_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output sfb_pkg::t_job o_job
);
    import sfb_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wr;
    logic [QW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != CW'(0));
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/sfb_back.sv =====
module sfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  sfb_pkg::t_job i_job,
    sfb_frame_if.source   o_frame
);
    import sfb_pkg::*;

    logic             r_busy;
    logic             r_out_valid;
    logic [POS_W-1:0] r_pos;
    t_job             r_job;
    logic [15:0]      r_crc;
    logic [7:0]       r_byte;
    logic             r_last;

    logic       load;
    logic       advance;
    logic [7:0] n_byte;
    logic       n_last;

    assign o_job_ready = !r_busy;
    assign load        = !r_busy && i_job_valid;
    assign advance     = r_busy && (!r_out_valid || o_frame.ready);

    always_comb begin
        n_byte = 8'h00;
        if (r_pos == POS_W'(0)) begin
            n_byte = r_job.command[15:8];
        end else if (r_pos == POS_W'(1)) begin
            n_byte = r_job.command[7:0];
        end else if (r_job.crc_on && (r_pos == r_job.crc_pos)) begin
            n_byte = r_crc[15:8];
        end else if (r_job.crc_on && (r_pos == r_job.crc_pos + POS_W'(1))) begin
            n_byte = r_crc[7:0];
        end
        n_last = (r_pos == r_job.total - POS_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (advance) begin
                r_pos <= r_pos + POS_W'(1);
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
            r_crc <= CRC_SEED;
        end else if (advance && (r_pos < r_job.covered)) begin
            r_crc <= crc_byte(r_crc, n_byte);
        end
        if (advance) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_byte;
    assign o_frame.last_byte  = r_last;

endmodule

// ===== src/spi_command_frame_builder.sv =====
// after the command transfer, the command is queued, loaded into the serializer, and its first byte is registered
// a frame of N bytes (2..24) is sent per command: the serializer loads the job, then
// sends one byte per cycle while the receiver is ready; crc is folded in as bytes are sent
// a 2-entry queue between classifier and serializer absorbs commands while a frame runs
// synchronous active-low reset clears the queue and the output; registers return to
// defaults: 3-byte words, 4 channels, fixed frame, crc off
module spi_command_frame_builder #(
    parameter int MAX_CHANNELS = sfb_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sfb_cmd_if.sink                        i_cmd,
    sfb_frame_if.source                    o_frame
);
    import sfb_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic back_ready;

    sfb_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .i_q_ready  (queue_ready),
        .o_q_valid  (front_valid),
        .o_job      (front_job)
    );

    sfb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (queue_ready),
        .i_job        (front_job),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (back_ready),
        .o_job        (queue_job)
    );

    sfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .o_job_ready (back_ready),
        .i_job       (queue_job),
        .o_frame     (o_frame)
    );

endmodule

// ===== src/sfb_checker.sv =====
`include "spi_command_frame_builder_assert.svh"

module sfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // stalled byte holds
    `SFB_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
    // bytes of one frame follow without gaps
    `SFB_ASSERT_NEXT(a_frame_continues, i_out_valid && i_out_ready && !i_out_last, i_out_valid)
    // stalled command stays offered
    `SFB_ASSERT_NEXT(a_in_hold, i_in_valid && !i_in_ready, i_in_valid)
    `SFB_ASSERT_ALWAYS_NEXT(a_reset_out_idle, !i_rst_n, !i_out_valid)
    `SFB_ASSERT_ALWAYS_NEXT(a_reset_in_ready, !i_rst_n, i_in_ready)

endmodule

bind spi_command_frame_builder sfb_checker u_sfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_out_byte  (o_frame.frame_byte),
    .i_out_last  (o_frame.last_byte)
);

// ===== sim/spi_command_frame_builder_checker.sv =====
module spi_command_frame_builder_checker #(
    parameter int MAX_CHANNELS = sfb_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sfb_cmd_if                             i_cmd,
    sfb_frame_if                           i_frame,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfb_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_beat;

    t_frame_beat frame_due[$];

    logic [2:0] cfg_word_bytes;
    logic [2:0] cfg_channels;
    logic       cfg_fixed;
    logic       cfg_crc_on;
    logic       cfg_crc_all;
    logic       cfg_conv_on;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] din);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int b = 7; b >= 0; b--) begin
            fb  = acc[15] ^ din[b];
            acc = acc << 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void build_frame(input logic [15:0] cmd);
        logic [7:0]  frame_img [FRAME_BYTES_MAX];
        logic [15:0] crc;
        int          wb;
        int          ch;
        int          words;
        int          total;
        int          covered;
        int          crc_at;
        wb = (cfg_word_bytes < 2) ? 2 : (cfg_word_bytes > 4) ? 4 : int'(cfg_word_bytes);
        ch = (cfg_channels == 0) ? 1 :
             (cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_channels);
        if (cfg_fixed) begin
            words = 2 + ch;
        end else begin
            words = 1 + (cfg_conv_on ? ch : 0) + (cfg_crc_on ? 1 : 0);
        end
        if (words * wb > FRAME_BYTES_MAX) begin
            words = FRAME_BYTES_MAX / wb;
        end
        total = words * wb;
        foreach (frame_img[k]) begin
            frame_img[k] = 8'h00;
        end
        frame_img[0] = cmd[15:8];
        frame_img[1] = cmd[7:0];
        // crc word sits at the start of the last word
        if (cfg_crc_on && words >= 2) begin
            covered = cfg_crc_all ? (words - 1) * wb : wb;
            crc     = CRC_SEED;
            for (int k = 0; k < covered; k++) begin
                crc = crc16_step(crc, frame_img[k]);
            end
            crc_at                = (words - 1) * wb;
            frame_img[crc_at]     = crc[15:8];
            frame_img[crc_at + 1] = crc[7:0];
        end
        for (int k = 0; k < total; k++) begin
            frame_due.push_back(t_frame_beat'{frame_img[k], (k == total - 1)});
        end
    endfunction

    task automatic check_beat(input logic [7:0] got_byte, input logic got_last);
        t_frame_beat want;
        if (frame_due.size() == 0) begin
            report_mismatch($sformatf("byte %h with no frame pending", got_byte));
        end else begin
            want = frame_due.pop_front();
            if (got_byte !== want.value) begin
                report_mismatch($sformatf("frame_byte got %h want %h", got_byte, want.value));
            end
            if (got_last !== want.last) begin
                report_mismatch($sformatf("last_byte got %b want %b on byte %h",
                                          got_last, want.last, want.value));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_word_bytes = 3'd3;
            cfg_channels   = 3'd4;
            cfg_fixed      = 1'b1;
            cfg_crc_on     = 1'b0;
            cfg_crc_all    = 1'b0;
            cfg_conv_on    = 1'b0;
            frame_due.delete();
        end else begin
            if (i_frame.valid && i_frame.ready) begin
                check_beat(i_frame.frame_byte, i_frame.last_byte);
            end
            if (i_cmd.valid && i_cmd.ready) begin
                build_frame(i_cmd.command_word);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WORD_BYTES:    cfg_word_bytes = i_cfg_data[2:0];
                    CFG_CHANNEL_COUNT: cfg_channels   = i_cfg_data[2:0];
                    CFG_FIXED_FRAME:   cfg_fixed      = i_cfg_data[0];
                    CFG_CRC_ENABLE:    cfg_crc_on     = i_cfg_data[0];
                    CFG_CRC_ALL_WORDS: cfg_crc_all    = i_cfg_data[0];
                    CFG_CONV_ENABLED:  cfg_conv_on    = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = frame_due.size();
    end

endmodule

// ===== sim/spi_command_frame_builder_tb.sv =====
module spi_command_frame_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfb_pkg::*;

    localparam real CLK_PERIOD     = 8.0;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  LONG_HOLD      = 300;
    localparam int  TAIL_CYCLES    = 32;
    localparam int  RAND_PHASES    = 10;
    localparam int  PHASE_ITEMS    = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit rx_hold_req = 1'b0;
    bit rx_steady   = 1'b0;
    bit tx_steady   = 1'b0;

    sfb_cmd_if   cmd_if ();
    sfb_frame_if frame_if ();

    spi_command_frame_builder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_frame    (frame_if)
    );

    spi_command_frame_builder_checker u_frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_cmd        (cmd_if),
        .i_frame      (frame_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (frame_if.valid && frame_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: on/off runs, a steady mode, and one long hold on request
    initial begin
        int  hold_left;
        int  run_left;
        bit  run_on;
        hold_left      = 0;
        run_left       = 0;
        run_on         = 1'b0;
        frame_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                frame_if.ready <= 1'b0;
                hold_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD - 1;
                frame_if.ready <= 1'b0;
            end else if (rx_steady) begin
                frame_if.ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_on   = !run_on;
                    run_left = run_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                frame_if.ready <= run_on;
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic apply_config(input logic [2:0] wb, input logic [2:0] ch,
                                input logic [2:0] fixed, input logic [2:0] crc_on,
                                input logic [2:0] crc_all, input logic [2:0] conv_on,
                                input bit spare);
        wait_drained();
        cfg_write(CFG_WORD_BYTES, wb);
        cfg_write(CFG_CHANNEL_COUNT, ch);
        cfg_write(CFG_FIXED_FRAME, fixed);
        cfg_write(CFG_CRC_ENABLE, crc_on);
        cfg_write(CFG_CRC_ALL_WORDS, crc_all);
        cfg_write(CFG_CONV_ENABLED, conv_on);
        if (spare) begin
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      CFG_DATA_W'($urandom_range(0, 7)));
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_command(input logic [15:0] cmd);
        cmd_if.valid        <= 1'b1;
        cmd_if.command_word <= cmd;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic directed_case(input logic [2:0] wb, input logic [2:0] ch,
                                 input logic [2:0] fixed, input logic [2:0] crc_on,
                                 input logic [2:0] crc_all, input logic [2:0] conv_on,
                                 input bit spare, input logic [15:0] c0,
                                 input logic [15:0] c1);
        apply_config(wb, ch, fixed, crc_on, crc_all, conv_on, spare);
        send_command(c0);
        send_command(c1);
        cmd_if.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_command();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int burst_left;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        cmd_if.valid        = 1'b0;
        cmd_if.command_word = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: fixed frame, 3-byte words, 4 channels, crc off
        send_command(16'h0000);
        send_command(16'hFFFF);
        send_command(16'h8001);
        send_command(16'h7FFE);
        cmd_if.valid <= 1'b0;

        directed_case(3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 1'b0, 16'h1234, 16'hFFFF);
        directed_case(3'd4, 3'd4, 3'd1, 3'd1, 3'd1, 3'd0, 1'b0, 16'h0000, 16'hA5C3);
        directed_case(3'd2, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 1'b0, 16'hFFFF, 16'h0001);
        // word size and channel count below range
        directed_case(3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 1'b0, 16'h8000, 16'h7FFF);
        // above range, all-words flag set with crc off
        directed_case(3'd7, 3'd7, 3'd0, 3'd0, 3'd1, 3'd1, 1'b0, 16'h00FF, 16'hFF00);
        // unused register index must be ignored
        directed_case(3'd1, 3'd5, 3'd1, 3'd1, 3'd1, 3'd0, 1'b1, 16'h5A5A, 16'hC3A5);
        directed_case(3'd5, 3'd3, 3'd0, 3'd1, 3'd0, 3'd0, 1'b0, 16'h0F0F, 16'hF0F0);
        directed_case(3'd3, 3'd2, 3'd0, 3'd1, 3'd1, 3'd1, 1'b0, 16'h4321, 16'hBEEF);

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            apply_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                         $urandom_range(0, 3) == 0);
            rx_steady = (phase == 2 || phase == 3);
            tx_steady = (phase == 3 || phase == 5);
            if (phase == 5) begin
                rx_hold_req = 1'b1;
            end
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    if (!tx_steady) begin
                        cmd_if.valid <= 1'b0;
                        repeat ($urandom_range(1, 20)) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 8);
                end
                send_command(pick_command());
                burst_left--;
            end
            cmd_if.valid <= 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
